// ===== sv/rgbyuv_pkg.sv =====
package rgbyuv_pkg;

    localparam int PIX_W  = 8;
    localparam int CH_W   = 15;   // 32*c plus offset, signed
    localparam int ACC_W  = 36;   // coefficient product sums
    localparam int FRAC_W = 24;
    localparam int YUV_W  = 10;   // Y, U, V span 0..256
    localparam int WORD_W = 16;

    localparam int SCALE_SH = 5;  // channel scaled by 32
    localparam int BIAS     = 'h18;
    localparam logic signed [CH_W-1:0] R_OFS = CH_W'('h166F - BIAS);
    localparam logic signed [CH_W-1:0] G_OFS = CH_W'(-'h10EE - BIAS);
    localparam logic signed [CH_W-1:0] B_OFS = CH_W'('h1C5B - BIAS);

    // BT.601 coefficients, 24 fraction bits
    localparam logic signed [ACC_W-1:0] C_YR = 156544;
    localparam logic signed [ACC_W-1:0] C_YG = 307926;
    localparam logic signed [ACC_W-1:0] C_YB = 59818;
    localparam logic signed [ACC_W-1:0] C_UR = -88466;
    localparam logic signed [ACC_W-1:0] C_UG = -174017;
    localparam logic signed [ACC_W-1:0] C_UB = 262481;
    localparam logic signed [ACC_W-1:0] C_VR = 262968;
    localparam logic signed [ACC_W-1:0] C_VG = -220193;
    localparam logic signed [ACC_W-1:0] C_VB = -42775;

    typedef struct packed {
        logic signed [YUV_W-1:0] luma;
        logic signed [YUV_W-1:0] cb;
        logic signed [YUV_W-1:0] cr;
        logic                    first;
    } yuv_t;

endpackage

// ===== sv/rgbyuv_if.sv =====
interface rgbyuv_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       first_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output first_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input first_of_frame, output ready);
endinterface

interface rgbyuv_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] luma_cb_word;
    logic [15:0] luma_cr_word;

    modport source (output valid, output luma_cb_word, output luma_cr_word,
                    input ready);
    modport sink   (input valid, input luma_cb_word, input luma_cr_word,
                    output ready);
endinterface

// ===== sv/rgbyuv_csc.sv =====
// Three-stage color conversion: input register, products, truncated sums.
module rgbyuv_csc (
    input  logic               clk,
    input  logic               rst_n,
    rgbyuv_pix_if.sink         pix,
    output logic               yuv_valid,
    input  logic               yuv_ready,
    output rgbyuv_pkg::yuv_t   yuv
);
    import rgbyuv_pkg::*;

    // truncate toward zero on the divide by 2^24
    function automatic logic signed [YUV_W-1:0] fix_trunc(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = acc >>> FRAC_W;
        if (acc[ACC_W-1] && (|acc[FRAC_W-1:0]))
        begin
            q = q + ACC_W'(1);
        end
        return q[YUV_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sext(input logic signed [CH_W-1:0] c);
        return $signed({{(ACC_W-CH_W){c[CH_W-1]}}, c});
    endfunction

    // stage 1: registered pixel
    logic             s1_valid_reg;
    logic [PIX_W-1:0] r_reg, g_reg, b_reg;
    logic             s1_first_reg;

    // stage 2: products
    logic                    s2_valid_reg;
    logic signed [ACC_W-1:0] p_reg [9];
    logic                    s2_first_reg;

    // stage 3: Y, U, V
    logic s3_valid_reg;
    yuv_t s3_reg;

    logic rdy1, rdy2, rdy3;
    logic signed [CH_W-1:0] rs, gs, bs;
    logic signed [ACC_W-1:0] p_next [9];
    logic signed [ACC_W-1:0] y_acc, u_acc, v_acc;
    yuv_t s3_next;

    assign rdy3      = !s3_valid_reg || yuv_ready;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign pix.ready = rdy1;

    always_comb
    begin
        rs = $signed({2'b00, r_reg, SCALE_SH'(0)}) + R_OFS;
        gs = $signed({2'b00, g_reg, SCALE_SH'(0)}) + G_OFS;
        bs = $signed({2'b00, b_reg, SCALE_SH'(0)}) + B_OFS;
        p_next[0] = sext(rs) * C_YR;
        p_next[1] = sext(gs) * C_YG;
        p_next[2] = sext(bs) * C_YB;
        p_next[3] = sext(rs) * C_UR;
        p_next[4] = sext(gs) * C_UG;
        p_next[5] = sext(bs) * C_UB;
        p_next[6] = sext(rs) * C_VR;
        p_next[7] = sext(gs) * C_VG;
        p_next[8] = sext(bs) * C_VB;
    end

    always_comb
    begin
        y_acc = p_reg[0] + p_reg[1] + p_reg[2];
        u_acc = p_reg[3] + p_reg[4] + p_reg[5];
        v_acc = p_reg[6] + p_reg[7] + p_reg[8];
        s3_next.luma  = fix_trunc(y_acc);
        s3_next.cb    = fix_trunc(u_acc);
        s3_next.cr    = fix_trunc(v_acc);
        s3_next.first = s2_first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= pix.valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pix.valid)
        begin
            r_reg        <= pix.red;
            g_reg        <= pix.green;
            b_reg        <= pix.blue;
            s1_first_reg <= pix.first_of_frame;
        end
        if (rdy2 && s1_valid_reg)
        begin
            p_reg        <= p_next;
            s2_first_reg <= s1_first_reg;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign yuv_valid = s3_valid_reg;
    assign yuv       = s3_reg;

endmodule

// ===== sv/rgb_to_yuv422_packer.sv =====
// Channel  Dir  Payload                                   Transaction
// pix      in   red, green, blue [7:0], first_of_frame    one RGB888 pixel
// word     out  luma_cb_word, luma_cr_word [15:0]         one YUV422 pixel pair
//
// One pixel per clock sustained while word is not stalled. The word is offered
// once the second pixel of a pair has passed the input register, which loads on
// the accepting edge, then the product, truncated-sum and output registers.
// Reset clears all valid flags and the pairing toggle; data registers are
// not reset. A stall on word backs up stage by stage; bubbles are absorbed,
// and first-of-pair pixels keep flowing while the output is held.
module rgb_to_yuv422_packer (
    input  logic          clk,
    input  logic          rst_n,
    rgbyuv_pix_if.sink    pix,
    rgbyuv_word_if.source word
);
    import rgbyuv_pkg::*;

    // average of two values, truncated toward zero
    function automatic logic signed [YUV_W-1:0] avg2(
        input logic signed [YUV_W-1:0] a, input logic signed [YUV_W-1:0] b);
        logic signed [YUV_W:0] s;
        logic signed [YUV_W:0] h;
        s = $signed({a[YUV_W-1], a}) + $signed({b[YUV_W-1], b});
        h = s >>> 1;
        if (s[YUV_W] && s[0])
        begin
            h = h + (YUV_W+1)'(1);
        end
        return h[YUV_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] clamp8(input logic signed [YUV_W-1:0] v);
        logic [PIX_W-1:0] c;
        if (v[YUV_W-1])
        begin
            c = '0;
        end
        else if (|v[YUV_W-2:PIX_W])
        begin
            c = '1;
        end
        else
        begin
            c = v[PIX_W-1:0];
        end
        return c;
    endfunction

    logic yuv_valid;
    logic yuv_ready;
    yuv_t yuv;

    rgbyuv_csc u_csc (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .yuv_valid (yuv_valid),
        .yuv_ready (yuv_ready),
        .yuv       (yuv)
    );

    // pairing state
    logic second_reg, second_next;
    logic signed [YUV_W-1:0] held_luma_reg, held_cb_reg, held_cr_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] cb_word_reg, cr_word_reg;
    logic [WORD_W-1:0] cb_word_next, cr_word_next;

    logic take;
    logic pair_done;

    // a second pixel needs the output register free; a first pixel never waits
    assign pair_done = second_reg && !yuv.first;
    assign yuv_ready = !pair_done || !out_valid_reg || word.ready;
    assign take      = yuv_valid && yuv_ready;

    always_comb
    begin
        second_next    = second_reg;
        out_valid_next = out_valid_reg && !word.ready;
        cb_word_next   = {clamp8(avg2(held_cb_reg, yuv.cb)), clamp8(held_luma_reg)};
        cr_word_next   = {clamp8(avg2(held_cr_reg, yuv.cr)), clamp8(yuv.luma)};
        if (take)
        begin
            if (pair_done)
            begin
                second_next    = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                // frame start or first of a pair: hold this pixel
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !pair_done)
        begin
            held_luma_reg <= yuv.luma;
            held_cb_reg   <= yuv.cb;
            held_cr_reg   <= yuv.cr;
        end
        if (take && pair_done)
        begin
            cb_word_reg <= cb_word_next;
            cr_word_reg <= cr_word_next;
        end
    end

    assign word.valid        = out_valid_reg;
    assign word.luma_cb_word = cb_word_reg;
    assign word.luma_cr_word = cr_word_reg;

endmodule

// ===== sv/rgbyuv_checker.sv =====
module rgbyuv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        word_valid,
    input logic        word_ready,
    input logic [15:0] luma_cb_word,
    input logic [15:0] luma_cr_word
);

    // held word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> word_valid)
        else $error("word valid dropped while stalled");

    // held word keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> $stable(luma_cb_word) && $stable(luma_cr_word))
        else $error("word payload changed while stalled");

    // nothing offered during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !word_valid)
        else $error("word valid during reset");

    // two pixels and four stages stand between reset and the first word
    a_first_latency: assert property (@(posedge clk)
        $rose(rst_n) |-> !word_valid ##1 !word_valid ##1 !word_valid
                         ##1 !word_valid ##1 !word_valid)
        else $error("word appeared too soon after reset");

endmodule

bind rgb_to_yuv422_packer rgbyuv_checker u_rgbyuv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word.valid),
    .word_ready   (word.ready),
    .luma_cb_word (word.luma_cb_word),
    .luma_cr_word (word.luma_cr_word)
);

// ===== test/yuv422_pair_check.sv =====
module yuv422_pair_check
    import rgbyuv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rgbyuv_pix_if  pix,
    rgbyuv_word_if word,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FRAC_SCALE = 64'sd16777216;   // 2^24

    typedef struct packed {
        logic [WORD_W-1:0] cb_word;
        logic [WORD_W-1:0] cr_word;
    } word_pair_t;

    word_pair_t pairs_due[$];

    // pairing state of the predictor
    logic                    half_held;
    logic signed [YUV_W-1:0] held_y;
    logic signed [YUV_W-1:0] held_u;
    logic signed [YUV_W-1:0] held_v;

    task automatic report(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // fixed-point sum to integer, truncating toward zero
    function automatic logic signed [YUV_W-1:0] fix_trunc(input longint acc);
        return YUV_W'(acc / FRAC_SCALE);
    endfunction

    function automatic logic [7:0] clip_byte(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] r, g, b, input logic sof);
        longint                  rs, gs, bs;
        logic signed [YUV_W-1:0] y, u, v;
        int                      u_avg, v_avg;
        word_pair_t              due;
        // scale by 32, remove bias, add per-channel offset
        rs = 32 * longint'(r) + 5719;
        gs = 32 * longint'(g) - 4358;
        bs = 32 * longint'(b) + 7235;
        y = fix_trunc(156544 * rs + 307926 * gs + 59818 * bs);
        u = fix_trunc(-88466 * rs - 174017 * gs + 262481 * bs);
        v = fix_trunc(262968 * rs - 220193 * gs - 42775 * bs);
        if (sof)
            half_held = 1'b0;
        if (!half_held)
        begin
            held_y    = y;
            held_u    = u;
            held_v    = v;
            half_held = 1'b1;
        end
        else
        begin
            u_avg = (int'(held_u) + int'(u)) / 2;
            v_avg = (int'(held_v) + int'(v)) / 2;
            due.cb_word = {clip_byte(u_avg), clip_byte(int'(held_y))};
            due.cr_word = {clip_byte(v_avg), clip_byte(int'(y))};
            pairs_due.push_back(due);
            half_held = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        word_pair_t due;
        if (!rst_n)
        begin
            half_held  = 1'b0;
            held_y     = '0;
            held_u     = '0;
            held_v     = '0;
            fail_count = 0;
            pairs_due.delete();
        end
        else
        begin
            if (word.valid && word.ready)
            begin
                if (pairs_due.size() == 0)
                    report($sformatf("unexpected word pair %h %h",
                                     word.luma_cb_word, word.luma_cr_word));
                else
                begin
                    due = pairs_due.pop_front();
                    if (word.luma_cb_word !== due.cb_word)
                        report($sformatf("luma_cb_word got %h want %h",
                                         word.luma_cb_word, due.cb_word));
                    if (word.luma_cr_word !== due.cr_word)
                        report($sformatf("luma_cr_word got %h want %h",
                                         word.luma_cr_word, due.cr_word));
                end
            end
            if (pix.valid && pix.ready)
                take_pixel(pix.red, pix.green, pix.blue, pix.first_of_frame);
        end
        pending <= pairs_due.size();
    end

endmodule

// ===== test/rgb_to_yuv422_packer_tb.sv =====
module rgb_to_yuv422_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbyuv_pkg::*;

    localparam int QUIET_LIMIT      = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES     = 16;    // four-stage pipe plus margin
    localparam int RANDOM_PER_PHASE = 250;

    logic clk = 1'b0;
    logic rst_n;

    // idle odds in percent, changed per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int fail_count;
    int pending;

    rgbyuv_pix_if  pix_ch();
    rgbyuv_word_if word_ch();

    rgb_to_yuv422_packer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .word  (word_ch)
    );

    // watches both channels, predicts every word pair and compares
    yuv422_pair_check pair_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix_ch),
        .word       (word_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: ready is redrawn every cycle against the current stall odds.
    always @(posedge clk)
        word_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Random channel value, biased toward the extremes 0 and 255.
    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // One pixel transaction. Optional idle cycles go in front, then valid
    // stays up until the block takes the pixel. Valid is never dropped and
    // raised in the same step: an idle gap only starts after acceptance.
    task automatic drive_pixel(input logic [PIX_W-1:0] r, g, b, input logic sof);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid          <= 1'b1;
        pix_ch.red            <= r;
        pix_ch.green          <= g;
        pix_ch.blue           <= b;
        pix_ch.first_of_frame <= sof;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    // Sender holds off until every predicted word pair has come out.
    task automatic drain_words();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed frames: frame start on the first pixel, random
    // frame length (odd ones leave a half pair for the next start to drop).
    // About one pixel in twenty gets its frame-start flag flipped.
    task automatic run_random(input int count);
        int   left;
        int   run;
        int   k;
        logic sof;
        left = count;
        while (left > 0)
        begin
            run = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
            for (k = 0; k < run && left > 0; k++)
            begin
                sof = (k == 0);
                if ($urandom_range(19) == 0)
                    sof = ~sof;
                drive_pixel(pick_channel(), pick_channel(), pick_channel(), sof);
                left--;
            end
        end
    endtask

    // Watchdog: ends the run when nothing is accepted for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pix_ch.valid && pix_ch.ready) || (word_ch.valid && word_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int src_pct[4];
        int sink_pct[4];
        int ph;
        // phases: no idling, sender idle, receiver stalling, both
        src_pct  = '{0, 63, 0, 23};
        sink_pct = '{0, 0, 63, 23};

        rst_n                 <= 1'b0;
        pix_ch.valid          <= 1'b0;
        pix_ch.red            <= '0;
        pix_ch.green          <= '0;
        pix_ch.blue           <= '0;
        pix_ch.first_of_frame <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back.
        // black and white pairs: lowest and highest Y
        drive_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        drive_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drive_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        // primaries and secondaries: U and V at both ends, clamping
        drive_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        drive_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        drive_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        drive_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        drive_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        drive_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        drive_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        drive_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        drive_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        drive_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        // frame start in the middle of a pair drops the held half
        drive_pixel(8'd10,  8'd20,  8'd30,  1'b0);
        drive_pixel(8'd200, 8'd100, 8'd50,  1'b1);
        drive_pixel(8'd5,   8'd5,   8'd5,   1'b0);
        // frame start on every pixel: no pair ever completes
        drive_pixel(8'd170, 8'd85,  8'd170, 1'b1);
        drive_pixel(8'd85,  8'd170, 8'd85,  1'b1);
        // frame start in the middle of a pair again
        drive_pixel(8'd128, 8'd127, 8'd1,   1'b1);
        drive_pixel(8'd254, 8'd1,   8'd128, 1'b0);
        // pair of green and magenta
        drive_pixel(8'd16,  8'd235, 8'd16,  1'b0);
        drive_pixel(8'd235, 8'd16,  8'd235, 1'b0);
        drain_words();

        // Random part, one phase per idle pattern; the sender waits for
        // every word pair between phases.
        for (ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            run_random(RANDOM_PER_PHASE);
            drain_words();
        end

        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
